FILE: hdl/hsc_pkg.sv
// Shared types, widths and bit-placement functions for the Hamming SEC codec.
// Used by hsc_cfg, hsc_core and hamming_sec_codec; depends on nothing else.
package hsc_pkg;

    localparam int MAX_DATA_BITS = 57;
    localparam int DATA_W        = 57;
    localparam int CW_W          = 63;
    localparam int SYN_W         = 6;
    localparam int CHK_W         = 3;
    localparam int CFG_W         = 6;
    localparam logic [CFG_W-1:0] DATA_BITS_RST = 6'd8;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_DATA_FIX  = 2'd1,
        STAT_CHECK_ERR = 2'd2,
        STAT_UNCORR    = 2'd3
    } status_t;

    typedef struct packed {
        logic [SYN_W-1:0]  n;
        logic [CW_W-1:0]   nmask;
        logic [DATA_W-1:0] dmask;
    } cfg_t;

    typedef struct packed {
        mode_t             mode;
        logic [DATA_W-1:0] data_in;
        logic [CW_W-1:0]   codeword_in;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [SYN_W-1:0]  syndrome;
        logic [DATA_W-1:0] data_out;
        logic [CW_W-1:0]   codeword_out;
    } result_t;

    function automatic logic is_pow2(input logic [SYN_W-1:0] v);
        return (v != '0) && ((v & (v - 1'b1)) == '0);
    endfunction

    function automatic logic [CHK_W-1:0] check_count(input logic [CFG_W-1:0] m);
        logic [CHK_W-1:0] r;
        logic             found;
        r     = '0;
        found = 1'b0;
        for (int i = 1; i <= 7; i++) begin
            if (!found && (((8'd1 << i) - 8'd1) >= ({2'b0, m} + 8'(i)))) begin
                r     = CHK_W'(i);
                found = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic cfg_t cfg_from_bits(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] m;
        logic [CHK_W-1:0] r;
        cfg_t             c;
        m = v;
        if (m == '0) begin
            m = 6'd1;
        end
        if (m > CFG_W'(MAX_DATA_BITS)) begin
            m = CFG_W'(MAX_DATA_BITS);
        end
        r   = check_count(m);
        c.n = m + {{(CFG_W-CHK_W){1'b0}}, r};
        for (int k = 0; k < CW_W; k++) begin
            c.nmask[k] = (7'(k) < {1'b0, c.n});
        end
        for (int k = 0; k < DATA_W; k++) begin
            c.dmask[k] = (7'(k) < {1'b0, m});
        end
        return c;
    endfunction

    function automatic logic [CW_W-1:0] place_data(input logic [DATA_W-1:0] d);
        logic [CW_W-1:0]  cw;
        logic [SYN_W-1:0] k;
        cw = '0;
        k  = '0;
        for (int pos = 1; pos <= CW_W; pos++) begin
            if (!is_pow2(SYN_W'(pos))) begin
                cw[pos-1] = d[k];
                k         = k + 1'b1;
            end
        end
        return cw;
    endfunction

    function automatic logic [DATA_W-1:0] extract_data(input logic [CW_W-1:0] cw);
        logic [DATA_W-1:0] d;
        logic [SYN_W-1:0]  k;
        d = '0;
        k = '0;
        for (int pos = 1; pos <= CW_W; pos++) begin
            if (!is_pow2(SYN_W'(pos))) begin
                d[k] = cw[pos-1];
                k    = k + 1'b1;
            end
        end
        return d;
    endfunction

    function automatic logic [CW_W-1:0] place_checks(input logic [SYN_W-1:0] s);
        logic [CW_W-1:0] cw;
        cw = '0;
        for (int i = 0; i < SYN_W; i++) begin
            cw[(1 << i) - 1] = s[i];
        end
        return cw;
    endfunction

    function automatic logic [SYN_W-1:0] syndrome_of(input logic [CW_W-1:0] cw);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int pos = 1; pos <= CW_W; pos++) begin
            if (cw[pos-1]) begin
                s = s ^ SYN_W'(pos);
            end
        end
        return s;
    endfunction

endpackage

FILE: hdl/hamming_sec_codec.sv
// Hamming single-error-correcting encoder/decoder, stream in and stream out.
// An accepted input waits in the input register; its result then moves to the result register,
// which drives m_tvalid, unless m_tready holds the output stage full.
// One transaction per cycle while m_tready does not stall; input register, one XOR-tree pass, result register.
// Backpressure from m_tready stalls both stages; each stage refills while its data leaves.
// Reset (aresetn low, synchronous) empties both stages and sets the data length to 8.
// Depends on hsc_pkg, hsc_cfg and hsc_core.
module hamming_sec_codec (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [hsc_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [119:0]                 s_tdata,   // data_in[56:0], codeword_in[119:57]
    input  logic                         s_tuser,   // mode[0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [127:0]                 m_tdata    // codeword_out[62:0], data_out[119:63],
                                                    // syndrome[125:120], status[127:126]
);

    hsc_pkg::cfg_t    cfg;
    hsc_pkg::item_t   item_reg;
    hsc_pkg::item_t   item_next;
    hsc_pkg::result_t result;
    hsc_pkg::result_t result_reg;
    logic             in_valid_reg;
    logic             in_valid_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_ready;
    logic             in_ready;

    hsc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hsc_core u_core (
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_comb begin
        out_ready      = !out_valid_reg || m_tready;
        in_ready       = !in_valid_reg || out_ready;
        in_valid_next  = in_ready ? s_tvalid : in_valid_reg;
        out_valid_next = out_ready ? in_valid_reg : out_valid_reg;
        item_next.mode        = hsc_pkg::mode_t'(s_tuser);
        item_next.data_in     = s_tdata[56:0];
        item_next.codeword_in = s_tdata[119:57];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && in_ready) begin
            item_reg <= item_next;
        end
        if (in_valid_reg && out_ready) begin
            result_reg <= result;
        end
    end

    assign s_tready = in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {result_reg.status, result_reg.syndrome,
                       result_reg.data_out, result_reg.codeword_out};

endmodule

FILE: hdl/hsc_cfg.sv
// Data-length register of the Hamming SEC codec with its derived code length and masks.
// Depends on hsc_pkg.
module hsc_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [hsc_pkg::CFG_W-1:0]      cfg_wdata,
    output hsc_pkg::cfg_t                  cfg
);

    hsc_pkg::cfg_t cfg_reg;
    hsc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = hsc_pkg::cfg_from_bits(cfg_wdata);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= hsc_pkg::cfg_from_bits(hsc_pkg::DATA_BITS_RST);
        end else if (cfg_we) begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/hsc_core.sv
// Encode and decode datapath of the Hamming SEC codec: syndrome tree, correction, data extract.
// Purely combinational; depends on hsc_pkg.
module hsc_core (
    input  hsc_pkg::item_t   item,
    input  hsc_pkg::cfg_t    cfg,
    output hsc_pkg::result_t result
);

    logic [hsc_pkg::CW_W-1:0]  placed;
    logic [hsc_pkg::CW_W-1:0]  rx_cw;
    logic [hsc_pkg::CW_W-1:0]  syn_src;
    logic [hsc_pkg::SYN_W-1:0] syn;
    logic [hsc_pkg::CW_W-1:0]  flip;
    logic [hsc_pkg::CW_W-1:0]  cw;
    hsc_pkg::status_t          status;

    always_comb begin
        placed  = hsc_pkg::place_data(item.data_in & cfg.dmask);
        rx_cw   = item.codeword_in & cfg.nmask;
        syn_src = (item.mode == hsc_pkg::MODE_DECODE) ? rx_cw : placed;
        syn     = hsc_pkg::syndrome_of(syn_src);

        for (int k = 0; k < hsc_pkg::CW_W; k++) begin
            flip[k] = (syn == hsc_pkg::SYN_W'(k + 1));
        end

        if (syn == '0) begin
            status = hsc_pkg::STAT_OK;
        end else if (syn > cfg.n) begin
            status = hsc_pkg::STAT_UNCORR;
        end else if (hsc_pkg::is_pow2(syn)) begin
            status = hsc_pkg::STAT_CHECK_ERR;
        end else begin
            status = hsc_pkg::STAT_DATA_FIX;
        end

        if (item.mode == hsc_pkg::MODE_DECODE) begin
            cw = (status == hsc_pkg::STAT_DATA_FIX) ? (rx_cw ^ flip) : rx_cw;
            result.syndrome = syn;
            result.status   = status;
        end else begin
            cw = placed | hsc_pkg::place_checks(syn);
            result.syndrome = '0;
            result.status   = hsc_pkg::STAT_OK;
        end

        result.codeword_out = cw;
        result.data_out     = hsc_pkg::extract_data(cw);
    end

endmodule

FILE: test/tb_hamming_sec_codec.sv
`timescale 1ns / 100ps
// Testbench for hamming_sec_codec: directed vectors, then random encode/decode traffic.
// Results are checked against typed expected words or a local Hamming predictor. Depends on hsc_pkg and the codec RTL.
module tb_hamming_sec_codec;

    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_ITEMS = 60;
    localparam logic [hsc_pkg::DATA_W-1:0] DATA_ONES = {hsc_pkg::DATA_W{1'b1}};
    localparam logic [hsc_pkg::CW_W-1:0] CW_ONES = {hsc_pkg::CW_W{1'b1}};

    typedef struct {
        bit                         wr_cfg;
        logic [hsc_pkg::CFG_W-1:0]  cfg;
        hsc_pkg::mode_t             mode;
        logic [hsc_pkg::DATA_W-1:0] din;
        logic [hsc_pkg::CW_W-1:0]   cwin;
        bit                         typed;
        hsc_pkg::result_t           want;
    } vec_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [hsc_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [119:0] s_tdata = '0;   // data_in[56:0], codeword_in[119:57]
    logic s_tuser = 1'b0;         // mode[0]
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [127:0] m_tdata;        // codeword_out[62:0], data_out[119:63],
                                  // syndrome[125:120], status[127:126]

    logic [hsc_pkg::CFG_W-1:0] cfg_bits = hsc_pkg::DATA_BITS_RST;
    hsc_pkg::result_t predicted_words[$];
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int idle_cycles = 0;
    hsc_pkg::result_t mon_got, mon_want;
    vec_t dir_vecs[22];

    hamming_sec_codec dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int code_len(input logic [hsc_pkg::CFG_W-1:0] bits);
        int m;
        int r;
        m = bits;
        if (m < 1) begin
            m = 1;
        end
        if (m > hsc_pkg::MAX_DATA_BITS) begin
            m = hsc_pkg::MAX_DATA_BITS;
        end
        r = 1;
        while (((1 << r) - 1) < m + r) begin
            r++;
        end
        return m + r;
    endfunction

    function automatic hsc_pkg::result_t hamming_predict(
        input hsc_pkg::mode_t mode,
        input logic [hsc_pkg::DATA_W-1:0] din,
        input logic [hsc_pkg::CW_W-1:0] cwin,
        input logic [hsc_pkg::CFG_W-1:0] bits);
        int n;
        int k;
        int syn;
        int par;
        logic [hsc_pkg::CW_W-1:0] cw;
        logic [hsc_pkg::DATA_W-1:0] dout;
        hsc_pkg::status_t st;
        hsc_pkg::result_t res;
        n = code_len(bits);
        cw = '0;
        syn = 0;
        par = 0;
        st = hsc_pkg::STAT_OK;
        if (mode == hsc_pkg::MODE_ENCODE) begin
            k = 0;
            for (int pos = 1; pos <= n; pos++) begin
                if ((pos & (pos - 1)) != 0) begin
                    if (din[k]) begin
                        cw[pos-1] = 1'b1;
                        par ^= pos;
                    end
                    k++;
                end
            end
            for (int i = 0; (1 << i) <= n; i++) begin
                if (par[i]) begin
                    cw[(1 << i) - 1] = 1'b1;
                end
            end
        end else begin
            for (int pos = 1; pos <= n; pos++) begin
                if (cwin[pos-1]) begin
                    cw[pos-1] = 1'b1;
                    syn ^= pos;
                end
            end
            if (syn == 0) begin
                st = hsc_pkg::STAT_OK;
            end else if (syn > n) begin
                st = hsc_pkg::STAT_UNCORR;
            end else if ((syn & (syn - 1)) == 0) begin
                st = hsc_pkg::STAT_CHECK_ERR;
            end else begin
                cw[syn-1] = ~cw[syn-1];
                st = hsc_pkg::STAT_DATA_FIX;
            end
        end
        dout = '0;
        k = 0;
        for (int pos = 1; pos <= n; pos++) begin
            if ((pos & (pos - 1)) != 0) begin
                dout[k] = cw[pos-1];
                k++;
            end
        end
        res.codeword_out = cw;
        res.data_out = dout;
        res.syndrome = syn[hsc_pkg::SYN_W-1:0];
        res.status = st;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (predicted_words.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [hsc_pkg::CFG_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_bits = v;
    endtask

    task automatic send_item(input hsc_pkg::mode_t mode,
                             input logic [hsc_pkg::DATA_W-1:0] din,
                             input logic [hsc_pkg::CW_W-1:0] cwin, input bit typed,
                             input hsc_pkg::result_t want);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {cwin, din};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        predicted_words.push_back(typed ? want : hamming_predict(mode, din, cwin, cfg_bits));
    endtask

    // hold off for a long stretch once requested, otherwise stall at random
    always @(posedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mon_got = m_tdata;
            if (predicted_words.size() == 0) begin
                report_mismatch("unexpected result", 64'(mon_got.codeword_out), '0);
            end else begin
                mon_want = predicted_words.pop_front();
                if (mon_got.codeword_out !== mon_want.codeword_out) begin
                    report_mismatch("codeword_out", 64'(mon_got.codeword_out),
                                    64'(mon_want.codeword_out));
                end
                if (mon_got.data_out !== mon_want.data_out) begin
                    report_mismatch("data_out", 64'(mon_got.data_out), 64'(mon_want.data_out));
                end
                if (mon_got.syndrome !== mon_want.syndrome) begin
                    report_mismatch("syndrome", 64'(mon_got.syndrome), 64'(mon_want.syndrome));
                end
                if (mon_got.status !== mon_want.status) begin
                    report_mismatch("status", 64'(mon_got.status), 64'(mon_want.status));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [hsc_pkg::CFG_W-1:0] phase_bits[8];
        int n;
        int kind;
        hsc_pkg::mode_t mode;
        logic [hsc_pkg::DATA_W-1:0] din;
        logic [hsc_pkg::CW_W-1:0] cwin;
        logic [63:0] rnd;
        hsc_pkg::result_t enc;

        // directed vectors start from the reset length of 8 data bits (12-bit codeword)
        dir_vecs = '{
            '{0, 6'd0,  hsc_pkg::MODE_ENCODE, 57'd0,     63'd0,
              1, '{hsc_pkg::STAT_OK, 6'd0, 57'd0, 63'd0}},
            '{0, 6'd0,  hsc_pkg::MODE_DECODE, 57'd0,     63'd0,
              1, '{hsc_pkg::STAT_OK, 6'd0, 57'd0, 63'd0}},
            '{0, 6'd0,  hsc_pkg::MODE_DECODE, 57'd0,     63'h1,
              1, '{hsc_pkg::STAT_CHECK_ERR, 6'd1, 57'd0, 63'h1}},
            '{0, 6'd0,  hsc_pkg::MODE_DECODE, 57'd0,     63'h4,
              1, '{hsc_pkg::STAT_DATA_FIX, 6'd3, 57'd0, 63'd0}},
            '{0, 6'd0,  hsc_pkg::MODE_DECODE, 57'd0,     63'h801,
              1, '{hsc_pkg::STAT_UNCORR, 6'd13, 57'h80, 63'h801}},
            '{0, 6'd0,  hsc_pkg::MODE_DECODE, 57'd0,     63'h80,
              1, '{hsc_pkg::STAT_CHECK_ERR, 6'd8, 57'd0, 63'h80}},
            '{0, 6'd0,  hsc_pkg::MODE_ENCODE, DATA_ONES, 63'd0,     0, '0},
            '{0, 6'd0,  hsc_pkg::MODE_DECODE, 57'd0,     CW_ONES,   0, '0},
            '{0, 6'd0,  hsc_pkg::MODE_ENCODE, 57'hA5,    63'd0,     0, '0},
            '{1, 6'd0,  hsc_pkg::MODE_ENCODE, 57'd1,     63'd0,     0, '0},
            '{0, 6'd0,  hsc_pkg::MODE_DECODE, 57'd0,     63'h7,     0, '0},
            '{0, 6'd0,  hsc_pkg::MODE_DECODE, 57'd0,     63'h4,     0, '0},
            '{1, 6'd57, hsc_pkg::MODE_ENCODE, DATA_ONES, 63'd0,     0, '0},
            '{0, 6'd0,  hsc_pkg::MODE_ENCODE, 57'd0,     63'd0,
              1, '{hsc_pkg::STAT_OK, 6'd0, 57'd0, 63'd0}},
            '{0, 6'd0,  hsc_pkg::MODE_DECODE, 57'd0,     CW_ONES,   0, '0},
            '{0, 6'd0,  hsc_pkg::MODE_DECODE, 57'd0,
              63'h1234_5678_9ABC_DEF0, 0, '0},
            '{1, 6'd63, hsc_pkg::MODE_DECODE, 57'd0,
              63'h4000_0000_0000_0000, 0, '0},
            '{0, 6'd0,  hsc_pkg::MODE_ENCODE, DATA_ONES, 63'd0,     0, '0},
            '{1, 6'd4,  hsc_pkg::MODE_DECODE, 57'd0,     63'h7F,    0, '0},
            '{0, 6'd0,  hsc_pkg::MODE_DECODE, 57'd0,     63'h40,    0, '0},
            '{1, 6'd1,  hsc_pkg::MODE_ENCODE, 57'd1,     63'd0,     0, '0},
            '{0, 6'd0,  hsc_pkg::MODE_DECODE, 57'd0,     63'h2,     0, '0}
        };
        phase_bits = '{6'd8, 6'd57, 6'd0, 6'd63, 6'd1, 6'd26, 6'($urandom_range(63)), 6'd11};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_vecs[v]) begin
            if (dir_vecs[v].wr_cfg) begin
                drain_pipe();
                write_cfg(dir_vecs[v].cfg);
            end
            send_item(dir_vecs[v].mode, dir_vecs[v].din, dir_vecs[v].cwin,
                      dir_vecs[v].typed, dir_vecs[v].want);
        end

        for (int p = 0; p < 8; p++) begin
            drain_pipe();
            write_cfg(phase_bits[p]);
            send_idle_pct = (p % 4 == 1) ? 62 : (p % 4 == 3) ? 31 : 0;
            recv_stall_pct = (p % 4 == 2) ? 62 : (p % 4 == 3) ? 31 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 0 && i == 10) begin
                    hold_req <= 1'b1;
                end
                if (p == 2 && i == 30) begin
                    drain_pipe();
                end
                rnd = {$urandom(), $urandom()};
                din = rnd[hsc_pkg::DATA_W-1:0];
                rnd = {$urandom(), $urandom()};
                cwin = rnd[hsc_pkg::CW_W-1:0];
                mode = ($urandom_range(1) != 0) ? hsc_pkg::MODE_DECODE : hsc_pkg::MODE_ENCODE;
                if (mode == hsc_pkg::MODE_DECODE) begin
                    // mostly valid codewords with zero, one or two flipped bits
                    kind = $urandom_range(9);
                    n = code_len(cfg_bits);
                    if (kind < 8) begin
                        enc = hamming_predict(hsc_pkg::MODE_ENCODE, din, '0, cfg_bits);
                        cwin = enc.codeword_out;
                        if (kind >= 3) begin
                            cwin[$urandom_range(n - 1)] ^= 1'b1;
                        end
                        if (kind == 7) begin
                            cwin[$urandom_range(n - 1)] ^= 1'b1;
                        end
                    end
                end
                send_item(mode, din, cwin, 1'b0, '0);
            end
        end

        drain_pipe();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/hsc_pkg.sv
hdl/hsc_cfg.sv
hdl/hsc_core.sv
hdl/hamming_sec_codec.sv
test/tb_hamming_sec_codec.sv
